### sv/wsg_pkg.sv
package wsg_pkg;

  // voice state layout
  localparam int NUM_VOICES = 3;
  localparam int VOICE_AW   = $clog2(NUM_VOICES);
  localparam int PHASE_W    = 20;
  localparam int NIB_COUNT  = 5;
  localparam int WAV_W      = 3;
  localparam int VOL_W      = 4;
  localparam int WAVE_AW    = 8;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 8;
  localparam int REG_COUNT  = 32;
  localparam int BIAS       = 8;

  // tick pipeline: read, update, accumulate, one voice entering per cycle
  localparam int TICK_LAST  = NUM_VOICES + 1;
  localparam int CNT_W      = $clog2(TICK_LAST + 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(25);

  typedef enum logic [1:0] {
    MODE_REG  = 2'd0,
    MODE_TICK = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REG_WR,
    ST_TICK,
    ST_GAIN
  } state_t;

  // nibble of accumulator/step, or the waveform/volume field
  typedef enum logic {
    FLD_PHASE,
    FLD_SEL
  } field_t;

  typedef struct packed {
    logic [PHASE_W-1:0] acc;
    logic [PHASE_W-1:0] step;
    logic [WAV_W-1:0]   wav;
    logic [VOL_W-1:0]   vol;
  } voice_t;

  typedef struct packed {
    field_t              fld;
    logic [VOICE_AW-1:0] voice;
    logic [2:0]          nib;
  } reg_dec_t;

  typedef struct packed {
    logic                en;
    logic [VOICE_AW-1:0] addr;
    voice_t              data;
  } voice_wr_t;

  typedef struct packed {
    logic clr;
    logic add;
  } mix_ctrl_t;

  // register map decode; same layout in both halves of the map
  function automatic reg_dec_t decode_reg(input logic [3:0] lo);
    reg_dec_t d;
    logic [3:0] off;
    d   = '{fld: FLD_PHASE, voice: '0, nib: '0};
    off = '0;
    case (lo) inside
      [4'd0:4'd4]: begin
        d.voice = VOICE_AW'(0);
        d.nib   = lo[2:0];
      end
      4'd5: begin
        d.fld   = FLD_SEL;
        d.voice = VOICE_AW'(0);
      end
      [4'd6:4'd9]: begin
        off     = lo - 4'd5;
        d.voice = VOICE_AW'(1);
        d.nib   = off[2:0];
      end
      4'd10: begin
        d.fld   = FLD_SEL;
        d.voice = VOICE_AW'(1);
      end
      [4'd11:4'd14]: begin
        off     = lo - 4'd10;
        d.voice = VOICE_AW'(2);
        d.nib   = off[2:0];
      end
      default: begin
        d.fld   = FLD_SEL;
        d.voice = VOICE_AW'(2);
      end
    endcase
    return d;
  endfunction

  // replace one nibble of a phase word
  function automatic logic [PHASE_W-1:0] put_nibble(input logic [PHASE_W-1:0] word,
                                                    input logic [2:0] nib,
                                                    input logic [3:0] v);
    logic [PHASE_W-1:0] w;
    w = word;
    for (int i = 0; i < NIB_COUNT; i++) begin
      if (nib == 3'(i)) begin
        w[4*i +: 4] = v;
      end
    end
    return w;
  endfunction

endpackage

### sv/wsg_voice_mem.sv
module wsg_voice_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  wsg_pkg::voice_wr_t           wr,
  input  logic [wsg_pkg::VOICE_AW-1:0] raddr,
  output wsg_pkg::voice_t              rdata
);

  wsg_pkg::voice_t                  mem [wsg_pkg::NUM_VOICES];
  logic [wsg_pkg::NUM_VOICES-1:0]   valid;
  wsg_pkg::voice_t                  rd_q;
  logic                             rd_hit;

  // storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  // per-entry valid bits stand in for the zero reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_hit <= valid[raddr];
    end
  end

  assign rdata = rd_hit ? rd_q : '0;

endmodule

### sv/wsg_wave_mem.sv
module wsg_wave_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [wsg_pkg::WAVE_AW-1:0] waddr,
  input  logic [wsg_pkg::BYTE_W-1:0]  wdata,
  input  logic [wsg_pkg::WAVE_AW-1:0] raddr,
  output logic [wsg_pkg::BYTE_W-1:0]  rdata
);

  logic [wsg_pkg::BYTE_W-1:0] mem [2**wsg_pkg::WAVE_AW];

  // waveform bytes, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/wsg_mixer.sv
module wsg_mixer (
  input  logic                         clk,
  input  wsg_pkg::mix_ctrl_t           ctrl,
  input  logic [wsg_pkg::BYTE_W-1:0]   wave_byte,
  input  logic [wsg_pkg::VOL_W-1:0]    vol,
  input  logic [wsg_pkg::GAIN_W-1:0]   gain,
  output logic [wsg_pkg::SAMPLE_W-1:0] mix_out
);

  logic [wsg_pkg::SAMPLE_W-1:0] biased;
  logic [wsg_pkg::SAMPLE_W-1:0] term;
  logic [wsg_pkg::SAMPLE_W-1:0] sum;

  // (byte - 8) * volume, 16-bit wrap
  assign biased = {{(wsg_pkg::SAMPLE_W-wsg_pkg::BYTE_W){1'b0}}, wave_byte}
                  - wsg_pkg::SAMPLE_W'(wsg_pkg::BIAS);
  assign term   = biased * {{(wsg_pkg::SAMPLE_W-wsg_pkg::VOL_W){1'b0}}, vol};

  // voice sum accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum <= '0;
    end else if (ctrl.add) begin
      sum <= sum + term;
    end
  end

  // output gain, low 16 bits
  assign mix_out = sum * {{(wsg_pkg::SAMPLE_W-wsg_pkg::GAIN_W){1'b0}}, gain};

endmodule

### sv/wavetable_sound_generator.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  mode, address, value
// output    out        out_valid / out_stall sample
// config    in         cfg_we               cfg_data (gain)
//
// register write (mode 0): read-modify-write of the voice entry.
// memory load (mode 2) and ignored items are taken without leaving idle.
// sample tick (mode 1): tick steps (voice read, one voice a cycle, last add), then the gain
// step, in which the result register loads; the next request is taken back in idle.
// reset (rst, synchronous) clears voice state via valid bits, gain to 25, no clearing pass.
// a result waiting on out_stall holds the block in the gain step; input stalls until idle.
module wavetable_sound_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [7:0]          address,
  input  logic [7:0]          value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  sample,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);

  wsg_pkg::state_t                  state;
  wsg_pkg::state_t                  state_next;
  wsg_pkg::mode_t                   in_mode;
  wsg_pkg::reg_dec_t                in_dec;
  wsg_pkg::reg_dec_t                item_dec;
  logic                             item_hi;
  logic [7:0]                       item_val;
  logic [wsg_pkg::CNT_W-1:0]        cnt;
  logic [wsg_pkg::GAIN_W-1:0]       gain;
  logic                             accept;
  logic                             out_load;

  wsg_pkg::voice_wr_t               vm_wr;
  logic [wsg_pkg::VOICE_AW-1:0]     vm_raddr;
  wsg_pkg::voice_t                  vm_rdata;
  wsg_pkg::voice_t                  reg_mod;

  logic                             calc_on;
  logic                             calc_live;
  logic [wsg_pkg::CNT_W-1:0]        calc_idx;
  logic [wsg_pkg::PHASE_W-1:0]      acc_new;
  logic                             calc_active;
  logic [wsg_pkg::VOL_W-1:0]        calc_vol;

  logic [wsg_pkg::WAVE_AW-1:0]      wm_raddr;
  logic [wsg_pkg::BYTE_W-1:0]       wm_rdata;
  wsg_pkg::mix_ctrl_t               mix_ctrl;
  logic [wsg_pkg::SAMPLE_W-1:0]     mix_out;

  assign in_mode  = wsg_pkg::mode_t'(mode);
  assign in_dec   = wsg_pkg::decode_reg(address[3:0]);
  assign in_stall = (state != wsg_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == wsg_pkg::ST_GAIN) && (!out_valid || !out_stall);

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      wsg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            wsg_pkg::MODE_REG: begin
              if (address < 8'(wsg_pkg::REG_COUNT)) begin
                state_next = wsg_pkg::ST_REG_WR;
              end
            end
            wsg_pkg::MODE_TICK: state_next = wsg_pkg::ST_TICK;
            wsg_pkg::MODE_LOAD: state_next = wsg_pkg::ST_IDLE;
            wsg_pkg::MODE_NONE: state_next = wsg_pkg::ST_IDLE;
          endcase
        end
      end
      wsg_pkg::ST_REG_WR: state_next = wsg_pkg::ST_IDLE;
      wsg_pkg::ST_TICK: begin
        if (cnt == wsg_pkg::CNT_W'(wsg_pkg::TICK_LAST)) begin
          state_next = wsg_pkg::ST_GAIN;
        end
      end
      wsg_pkg::ST_GAIN: begin
        if (out_load) begin
          state_next = wsg_pkg::ST_IDLE;
        end
      end
      default: state_next = wsg_pkg::ST_IDLE;
    endcase
  end

  // tick step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= '0;
    end else if (state == wsg_pkg::ST_TICK) begin
      cnt <= cnt + 1'b1;
    end
  end

  // request fields kept for the register write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      item_dec <= in_dec;
      item_hi  <= address[4];
      item_val <= value;
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= wsg_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  // voice read address: decoded voice on a write, next voice during a tick
  always_comb begin
    if (state == wsg_pkg::ST_TICK) begin
      if (cnt < wsg_pkg::CNT_W'(wsg_pkg::NUM_VOICES)) begin
        vm_raddr = cnt[wsg_pkg::VOICE_AW-1:0];
      end else begin
        vm_raddr = '0;
      end
    end else begin
      vm_raddr = in_dec.voice;
    end
  end

  // register write: patch the entry read in the accept cycle
  always_comb begin
    reg_mod = vm_rdata;
    if (item_dec.fld == wsg_pkg::FLD_PHASE) begin
      if (item_hi) begin
        reg_mod.step = wsg_pkg::put_nibble(vm_rdata.step, item_dec.nib, item_val[3:0]);
      end else begin
        reg_mod.acc = wsg_pkg::put_nibble(vm_rdata.acc, item_dec.nib, item_val[3:0]);
      end
    end else if (item_hi) begin
      reg_mod.vol = item_val[wsg_pkg::VOL_W-1:0];
    end else begin
      reg_mod.wav = item_val[wsg_pkg::WAV_W-1:0];
    end
  end

  // update stage: the voice read last cycle advances and addresses its wave byte
  assign calc_on   = (state == wsg_pkg::ST_TICK) && (cnt != '0)
                     && (cnt <= wsg_pkg::CNT_W'(wsg_pkg::NUM_VOICES));
  assign calc_idx  = cnt - 1'b1;
  assign calc_live = (|vm_rdata.step) && (|vm_rdata.vol);
  assign acc_new   = vm_rdata.acc + vm_rdata.step;
  assign wm_raddr  = {vm_rdata.wav, acc_new[wsg_pkg::PHASE_W-1 -: 5]};

  // voice write-back port
  always_comb begin
    vm_wr = '0;
    if (state == wsg_pkg::ST_REG_WR) begin
      vm_wr.en   = 1'b1;
      vm_wr.addr = item_dec.voice;
      vm_wr.data = reg_mod;
    end else if (calc_on && calc_live) begin
      vm_wr.en       = 1'b1;
      vm_wr.addr     = calc_idx[wsg_pkg::VOICE_AW-1:0];
      vm_wr.data     = vm_rdata;
      vm_wr.data.acc = acc_new;
    end
  end

  // update-to-accumulate stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calc_active <= 1'b0;
    end else begin
      calc_active <= calc_on && calc_live;
    end
  end

  always_ff @(posedge clk) begin
    calc_vol <= vm_rdata.vol;
  end

  assign mix_ctrl.clr = accept && (in_mode == wsg_pkg::MODE_TICK);
  assign mix_ctrl.add = calc_active;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample <= mix_out;
    end
  end

  wsg_voice_mem u_voice_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (vm_wr),
    .raddr (vm_raddr),
    .rdata (vm_rdata)
  );

  wsg_wave_mem u_wave_mem (
    .clk   (clk),
    .we    (accept && (in_mode == wsg_pkg::MODE_LOAD)),
    .waddr (address),
    .wdata (value),
    .raddr (wm_raddr),
    .rdata (wm_rdata)
  );

  wsg_mixer u_mixer (
    .clk       (clk),
    .ctrl      (mix_ctrl),
    .wave_byte (wm_rdata),
    .vol       (calc_vol),
    .gain      (gain),
    .mix_out   (mix_out)
  );

endmodule

### sv/wsg_checker.sv
module wsg_props (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] sample
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("stalled sample changed or dropped");

  // a sample tick request keeps the input busy
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == wsg_pkg::MODE_TICK) |=> in_stall)
    else $error("input not stalled after a tick request");

  // requests other than ticks never produce a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && !in_stall && (mode != wsg_pkg::MODE_TICK) |=> !out_valid)
    else $error("result without a tick request");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind wavetable_sound_generator wsg_props u_wsg_props (.*);
